/* rtl/sll_pkg.sv */
// ----------------------------------------------------------------------------
// sll_pkg: shared types and codes
// Request and response structs, action and status codes, controller commands.
// ----------------------------------------------------------------------------
package sll_pkg;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_SEARCH = 3'd2;
    localparam logic [2:0] ACT_READ   = 3'd3;
    localparam logic [2:0] ACT_HEAD   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_LIVE = 2'd2;
    localparam logic [1:0] ST_MISSING  = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] item_value;
        logic [3:0]         slot;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] result_value;
        logic [3:0]         result_slot;
        logic               result_slot_valid;
        logic [4:0]         entry_count;
    } rsp_t;

    typedef struct packed {
        logic load;       // capture request, start walk at head
        logic step;       // advance walk cursor
        logic do_insert;  // link new entry before cursor
        logic do_remove;  // unlink entry at request slot
        logic finish;     // form response
    } cmd_t;

    typedef struct packed {
        logic cur_none;
        logic stays;
        logic match;
    } stat_t;

endpackage

/* rtl/sorted_linked_list_engine.sv */
// ----------------------------------------------------------------------------
// sorted_linked_list_engine: sorted doubly linked list in slot stores
// Insert, remove, search, read and head requests on one list.
// ----------------------------------------------------------------------------
// Usage:
//   Requests transfer on in_valid/in_ready as a req_t; one response per
//   request transfers on out_valid/out_ready as a rsp_t.
//   order_wr/order_data set the ordering register; the user must write it
//   only while the block is idle, and the block does not enforce this.
//   Insert and search walk one slot per cycle, up to SLOT_COUNT slots;
//   remove, read and head skip the walk. Each response waits for out_ready.
//   One request is in flight at a time; in_ready drops until the response
//   transfers, so a stalled receiver holds the block.
//   Reset empties the list, chains all slots on the free list, sets order
//   ascending.
// ----------------------------------------------------------------------------
module sorted_linked_list_engine #(
    parameter int SLOT_COUNT = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          order_wr,
    input  logic          order_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  sll_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sll_pkg::rsp_t out_data
);
    import sll_pkg::*;

    logic  order_reg;
    cmd_t  cmd;
    stat_t stat;
    req_t  req_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)        order_reg <= 1'b0;
        else if (order_wr) order_reg <= order_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)        req_hold <= '0;
        else if (cmd.load) req_hold <= in_data;
    end

    sll_control u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .action   (req_hold.action),
        .stat     (stat),
        .cmd      (cmd)
    );

    sll_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .order_descending(order_reg),
        .req             (in_data),
        .cmd             (cmd),
        .stat            (stat),
        .rsp             (out_data)
    );
endmodule

/* rtl/sll_datapath.sv */
// ----------------------------------------------------------------------------
// sll_datapath: slot stores, links, free list and walk cursor
// Executes controller commands; reports cursor compare status.
// ----------------------------------------------------------------------------
module sll_datapath #(
    parameter int SLOT_COUNT = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          order_descending,
    input  sll_pkg::req_t req,
    input  sll_pkg::cmd_t cmd,
    output sll_pkg::stat_t stat,
    output sll_pkg::rsp_t rsp
);
    import sll_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int LW = $clog2(SLOT_COUNT + 1);
    localparam logic [LW-1:0] NONE = LW'(SLOT_COUNT);

    logic [31:0]   value_store [SLOT_COUNT];
    logic [LW-1:0] next_reg [SLOT_COUNT];
    logic [LW-1:0] prev_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] live_reg;
    logic [LW-1:0] free_reg, head_reg, tail_reg, cur_reg, prv_reg, count_reg;
    req_t          req_reg;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;

    logic [LW-1:0] rs;
    logic          slot_live, cur_none, free_none;
    logic [31:0]   cur_val;
    logic [LW-1:0] n_rm, p_rm;

    assign rs        = LW'(req_reg.slot);
    assign slot_live = (rs < NONE) && live_reg[rs[IW-1:0]];
    assign cur_none  = !(cur_reg < NONE);
    assign free_none = !(free_reg < NONE);
    assign cur_val   = value_store[cur_reg[IW-1:0]];
    assign n_rm      = next_reg[rs[IW-1:0]];
    assign p_rm      = prev_reg[rs[IW-1:0]];

    assign stat.cur_none = cur_none;
    assign stat.match    = (cur_val == req_reg.item_value);
    assign stat.stays    = order_descending ?
                           ($signed(cur_val) >= req_reg.item_value) :
                           ($signed(cur_val) <= req_reg.item_value);
    assign rsp = rsp_reg;

    always_comb
    begin
        rsp_next = '0;
        rsp_next.status = ST_MISSING;
        rsp_next.entry_count = 5'(count_reg);
        unique case (req_reg.action)
            ACT_INSERT:
                if (free_none) rsp_next.status = ST_FULL;
                else
                begin
                    rsp_next.status = ST_OK;
                    rsp_next.result_slot = 4'(free_reg);
                    rsp_next.result_slot_valid = 1'b1;
                    rsp_next.entry_count = 5'(count_reg + LW'(1));
                end
            ACT_REMOVE:
                if (!slot_live) rsp_next.status = ST_NOT_LIVE;
                else
                begin
                    rsp_next.status = ST_OK;
                    rsp_next.result_value = value_store[rs[IW-1:0]];
                    rsp_next.result_slot = (n_rm < NONE) ? 4'(n_rm) : 4'd0;
                    rsp_next.result_slot_valid = (n_rm < NONE);
                    rsp_next.entry_count = 5'(count_reg - LW'(1));
                end
            ACT_SEARCH:
                if (!cur_none)
                begin
                    rsp_next.status = ST_OK;
                    rsp_next.result_slot = 4'(cur_reg);
                    rsp_next.result_slot_valid = 1'b1;
                end
            ACT_READ:
                if (!slot_live) rsp_next.status = ST_NOT_LIVE;
                else
                begin
                    rsp_next.status = ST_OK;
                    rsp_next.result_value = value_store[rs[IW-1:0]];
                    rsp_next.result_slot = req_reg.slot;
                    rsp_next.result_slot_valid = 1'b1;
                end
            ACT_HEAD:
                if (head_reg < NONE)
                begin
                    rsp_next.status = ST_OK;
                    rsp_next.result_slot = 4'(head_reg);
                    rsp_next.result_slot_valid = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_insert && !free_none)
            value_store[free_reg[IW-1:0]] <= req_reg.item_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                next_reg[i] <= LW'(i + 1);
                prev_reg[i] <= NONE;
            end
            live_reg  <= '0;
            free_reg  <= '0;
            head_reg  <= NONE;
            tail_reg  <= NONE;
            count_reg <= '0;
            cur_reg   <= NONE;
            prv_reg   <= NONE;
            req_reg   <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                req_reg <= req;
                cur_reg <= head_reg;
                prv_reg <= NONE;
            end
            if (cmd.step)
            begin
                prv_reg <= cur_reg;
                cur_reg <= next_reg[cur_reg[IW-1:0]];
            end
            if (cmd.do_insert && !free_none)
            begin
                free_reg <= next_reg[free_reg[IW-1:0]];
                live_reg[free_reg[IW-1:0]] <= 1'b1;
                next_reg[free_reg[IW-1:0]] <= cur_reg;
                prev_reg[free_reg[IW-1:0]] <= prv_reg;
                if (prv_reg < NONE) next_reg[prv_reg[IW-1:0]] <= free_reg;
                else                head_reg <= free_reg;
                if (cur_reg < NONE) prev_reg[cur_reg[IW-1:0]] <= free_reg;
                else                tail_reg <= free_reg;
                count_reg <= count_reg + LW'(1);
            end
            if (cmd.do_remove && slot_live)
            begin
                if (p_rm < NONE) next_reg[p_rm[IW-1:0]] <= n_rm;
                else             head_reg <= n_rm;
                if (n_rm < NONE) prev_reg[n_rm[IW-1:0]] <= p_rm;
                else             tail_reg <= p_rm;
                next_reg[rs[IW-1:0]] <= free_reg;
                prev_reg[rs[IW-1:0]] <= NONE;
                live_reg[rs[IW-1:0]] <= 1'b0;
                free_reg  <= rs;
                count_reg <= count_reg - LW'(1);
            end
            if (cmd.finish)
                rsp_reg <= rsp_next;
        end
    end
endmodule

/* rtl/sll_control.sv */
// ----------------------------------------------------------------------------
// sll_control: request sequencer
// Accepts a request, walks the list as needed, then presents the response.
// ----------------------------------------------------------------------------
module sll_control (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  logic [2:0]     action,
    input  sll_pkg::stat_t stat,
    output sll_pkg::cmd_t  cmd
);
    import sll_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_WALK;
                end
            S_WALK:
                if (action == ACT_INSERT && !stat.cur_none && stat.stays)
                    cmd.step = 1'b1;
                else if (action == ACT_SEARCH && !stat.cur_none && !stat.match)
                    cmd.step = 1'b1;
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
            S_DONE:
            begin
                cmd.do_insert = (action == ACT_INSERT);
                cmd.do_remove = (action == ACT_REMOVE);
                state_next = S_OUT;
            end
            S_OUT:
                if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end
endmodule

/* verif/sorted_linked_list_engine_tb.sv */
// ----------------------------------------------------------------------------
// sorted_linked_list_engine_tb: self-checking bench for the sorted list engine
// Drives insert, remove, search, read and head requests with random idling,
// predicts every response from a local model of the slot stores and links,
// and compares each response field by field in order of arrival.
// ----------------------------------------------------------------------------
module sorted_linked_list_engine_tb;

    import sll_pkg::*;

    localparam int NSLOT = 16;
    localparam int NIL = NSLOT;
    localparam int WATCHDOG_LIMIT = 20000;

    class list_scoreboard;
        logic [31:0] vals [NSLOT];
        int          nxt [NSLOT];
        int          prv [NSLOT];
        bit          live [NSLOT];
        int          free_head;
        int          head;
        int          count;
        bit          descending;
        rsp_t        pending [$];
        int          mismatches;

        function void clear();
            for (int i = 0; i < NSLOT; i++)
            begin
                vals[i] = '0;
                nxt[i] = i + 1;
                prv[i] = NIL;
                live[i] = 0;
            end
            free_head = 0;
            head = NIL;
            count = 0;
            descending = 0;
            mismatches = 0;
            pending.delete();
        endfunction

        function bit stays(logic signed [31:0] a, logic signed [31:0] b);
            return descending ? (a >= b) : (a <= b);
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            int   n;
            int   cur;
            int   p;
            e = '0;
            e.status = ST_MISSING;
            case (r.action)
                ACT_INSERT:
                begin
                    if (free_head >= NIL)
                        e.status = ST_FULL;
                    else
                    begin
                        n = free_head;
                        free_head = nxt[n];
                        vals[n] = r.item_value;
                        live[n] = 1;
                        cur = head;
                        p = NIL;
                        while (cur < NIL && stays(vals[cur], r.item_value))
                        begin
                            p = cur;
                            cur = nxt[cur];
                        end
                        nxt[n] = cur;
                        prv[n] = p;
                        if (p < NIL) nxt[p] = n; else head = n;
                        if (cur < NIL) prv[cur] = n;
                        count++;
                        e.status = ST_OK;
                        e.result_slot = 4'(n);
                        e.result_slot_valid = 1;
                    end
                end
                ACT_REMOVE:
                begin
                    if (!live[r.slot])
                        e.status = ST_NOT_LIVE;
                    else
                    begin
                        n = nxt[r.slot];
                        p = prv[r.slot];
                        if (p < NIL) nxt[p] = n; else head = n;
                        if (n < NIL) prv[n] = p;
                        e.result_value = vals[r.slot];
                        nxt[r.slot] = free_head;
                        prv[r.slot] = NIL;
                        live[r.slot] = 0;
                        free_head = r.slot;
                        count--;
                        e.status = ST_OK;
                        if (n < NIL)
                        begin
                            e.result_slot = 4'(n);
                            e.result_slot_valid = 1;
                        end
                    end
                end
                ACT_SEARCH:
                begin
                    cur = head;
                    while (cur < NIL)
                    begin
                        if (vals[cur] == r.item_value)
                        begin
                            e.status = ST_OK;
                            e.result_slot = 4'(cur);
                            e.result_slot_valid = 1;
                            break;
                        end
                        cur = nxt[cur];
                    end
                end
                ACT_READ:
                begin
                    if (!live[r.slot])
                        e.status = ST_NOT_LIVE;
                    else
                    begin
                        e.status = ST_OK;
                        e.result_value = vals[r.slot];
                        e.result_slot = r.slot;
                        e.result_slot_valid = 1;
                    end
                end
                ACT_HEAD:
                begin
                    if (head < NIL)
                    begin
                        e.status = ST_OK;
                        e.result_slot = 4'(head);
                        e.result_slot_valid = 1;
                    end
                end
                default: ;
            endcase
            e.entry_count = 5'(count);
            pending.push_back(e);
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", got);
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status || got.result_value !== e.result_value
                || got.result_slot !== e.result_slot
                || got.result_slot_valid !== e.result_slot_valid
                || got.entry_count !== e.entry_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass

    logic  clk = 0;
    logic  rst_n = 0;
    logic  order_wr = 0;
    logic  order_data = 0;
    logic  in_valid = 0;
    logic  in_ready;
    req_t  in_data = '0;
    logic  out_valid;
    logic  out_ready = 0;
    rsp_t  out_data;

    list_scoreboard board;
    bit    calm;
    bit    hold_rx;
    int    idle_cycles = 0;
    int    recent [$];

    always #1 clk = ~clk;

    sorted_linked_list_engine #(.SLOT_COUNT(NSLOT)) DUT (
        .clk(clk), .rst_n(rst_n), .order_wr(order_wr), .order_data(order_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_request(in_data);
        if (rst_n && out_valid && out_ready)
            board.check_response(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sorted_linked_list_engine_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_rx)
                out_ready <= 0;
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 4);
                out_ready <= 0;
                repeat (n - 1) @(posedge clk);
            end
            else
                out_ready <= 1;
        end
    end

    task automatic send(input logic [2:0] act, input logic [31:0] v,
                        input logic [3:0] s);
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 4);
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_data <= '{action: act, item_value: v, slot: s};
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_order(input bit d);
        drain();
        order_wr <= 1;
        order_data <= d;
        @(posedge clk);
        order_wr <= 0;
        board.descending = d;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 6) - 3;
            3: if (recent.size() > 0) return recent[$urandom_range(0, recent.size() - 1)];
            default: ;
        endcase
        return $urandom;
    endfunction

    task automatic random_phase(input int count);
        logic [31:0] v;
        int a;
        for (int i = 0; i < count; i++)
        begin
            a = $urandom_range(0, 99);
            v = pick_value();
            if (a < 40)
            begin
                send(ACT_INSERT, v, 4'($urandom));
                recent.push_back(v);
                if (recent.size() > 32) void'(recent.pop_front());
            end
            else if (a < 62) send(ACT_REMOVE, v, 4'($urandom));
            else if (a < 78) send(ACT_SEARCH, v, 4'($urandom));
            else if (a < 90) send(ACT_READ, v, 4'($urandom));
            else if (a < 96) send(ACT_HEAD, v, 4'($urandom));
            else send(3'($urandom_range(5, 7)), v, 4'($urandom));
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        calm = 0;
        hold_rx = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(ACT_HEAD, 0, 0);
        send(ACT_SEARCH, 5, 0);
        send(ACT_READ, 0, 0);
        send(ACT_REMOVE, 0, 15);
        send(ACT_INSERT, 32'h7fff_ffff, 0);
        send(ACT_INSERT, 32'h8000_0000, 0);
        send(ACT_INSERT, 0, 0);
        send(ACT_INSERT, 0, 0);
        send(ACT_INSERT, 32'hffff_ffff, 0);
        send(ACT_SEARCH, 0, 0);
        send(ACT_READ, 0, 3);
        send(ACT_HEAD, 0, 0);
        send(ACT_REMOVE, 0, 0);
        send(ACT_REMOVE, 0, 0);
        send(ACT_READ, 0, 0);
        send(3'd5, 1, 1);
        send(3'd7, 32'hffff_ffff, 4'hf);
        for (int i = 0; i < 16; i++)
            send(ACT_INSERT, $urandom, 0);
        send(ACT_HEAD, 0, 0);

        fork
            begin
                hold_rx = 1;
                repeat (200) @(posedge clk);
                hold_rx = 0;
            end
            random_phase(40);
        join

        set_order(1);
        random_phase(400);
        set_order(0);
        random_phase(400);
        set_order(1);
        random_phase(250);
        set_order(0);
        calm = 1;
        random_phase(200);

        drain();
        if (board.mismatches == 0)
            $display("sorted_linked_list_engine_tb: done, clean");
        else
            $display("sorted_linked_list_engine_tb: done, errors");
        $finish;
    end

endmodule
